// ===== rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants for the Mandelbrot escape-time pixel block.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 31;
    localparam int ITER_W      = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_X_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_TOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_Y   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER = 3'd4;

    // reset values: -2.75, 1.0 in Q4.28, steps, limit
    localparam logic [COORD_W-1:0] X_LEFT_RST   = 32'hD400_0000;
    localparam logic [COORD_W-1:0] Y_TOP_RST    = 32'h1000_0000;
    localparam logic [STEP_W-1:0]  STEP_X_RST   = 31'd134235;
    localparam logic [STEP_W-1:0]  STEP_Y_RST   = 31'd134251;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 8'd255;

    typedef struct packed {
        logic [COORD_W-1:0] x_left;
        logic [COORD_W-1:0] y_top;
        logic [STEP_W-1:0]  step_x;
        logic [STEP_W-1:0]  step_y;
        logic [ITER_W-1:0]  max_iter;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CADD,
        ST_STEP,
        ST_SQR
    } state_t;

    typedef struct packed {
        logic load_in;
        logic load_c;
        logic step;
        logic square;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic esc;
        logic at_max;
    } dp_status_t;

endpackage

// ===== rtl/met_if.sv =====
// ----------------------------------------------------------------------------
// met_if
// Valid/ready channels for pixel coordinates and pixel results.
// ----------------------------------------------------------------------------
interface pixel_in_if #(
    parameter int INDEX_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] row;
    logic [INDEX_WIDTH-1:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink (input valid, input row, input col, output ready);
    modport monitor (input valid, input row, input col, input ready);
endinterface

interface pixel_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic       escaped;

    modport source (output valid, output pixel_value, output escaped, input ready);
    modport sink (input valid, input pixel_value, input escaped, output ready);
    modport monitor (input valid, input pixel_value, input escaped, input ready);
endinterface

// ===== rtl/met_cfg.sv =====
// ----------------------------------------------------------------------------
// met_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module met_cfg
    import met_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_LEFT:   cfg_next.x_left   = cfg_wdata[COORD_W-1:0];
                CFG_Y_TOP:    cfg_next.y_top    = cfg_wdata[COORD_W-1:0];
                CFG_STEP_X:   cfg_next.step_x   = cfg_wdata[STEP_W-1:0];
                CFG_STEP_Y:   cfg_next.step_y   = cfg_wdata[STEP_W-1:0];
                CFG_MAX_ITER: cfg_next.max_iter = cfg_wdata[ITER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_left   <= X_LEFT_RST;
            cfg_reg.y_top    <= Y_TOP_RST;
            cfg_reg.step_x   <= STEP_X_RST;
            cfg_reg.step_y   <= STEP_Y_RST;
            cfg_reg.max_iter <= MAX_ITER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/met_ctrl.sv =====
// ----------------------------------------------------------------------------
// met_ctrl
// Sequencer: accept, form c, alternate step and square until done.
// ----------------------------------------------------------------------------
module met_ctrl
    import met_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   finish;
    logic   out_free;

    assign finish   = status.esc || status.at_max;
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CADD;
            end
            ST_CADD:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (!finish)
                    state_next = ST_SQR;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SQR:
            begin
                state_next = ST_STEP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_CADD:
            begin
                cmd.load_c = 1'b1;
            end
            ST_STEP:
            begin
                cmd.step     = !finish;
                cmd.load_out = finish && out_free;
            end
            ST_SQR:
            begin
                cmd.square = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/met_dp.sv =====
// ----------------------------------------------------------------------------
// met_dp
// Datapath: c from the pixel index, z registers, three multipliers, counter,
// escape test and the result word register.
// ----------------------------------------------------------------------------
module met_dp
    import met_pkg::*;
#(
    parameter int FRAC_BITS   = 28,
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                   clk,
    input  cfg_t                   cfg,
    input  logic [INDEX_WIDTH-1:0] row,
    input  logic [INDEX_WIDTH-1:0] col,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [7:0]             pixel_value,
    output logic                   escaped
);

    localparam int PW = STEP_W + INDEX_WIDTH;                 // step * index
    localparam int CW = PW + 2;                               // c, signed
    localparam int ZW = ((CW > FRAC_BITS + 5) ? CW : FRAC_BITS + 5) + 1;
    localparam int MW = FRAC_BITS + 2;                        // magnitude below 2
    localparam logic signed [ZW-1:0] TWO = ZW'(1) << (FRAC_BITS + 1);

    logic [PW-1:0]        px_reg, py_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] zx_reg, zy_reg;
    logic [MW-1:0]        pxx_reg, pyy_reg;
    logic signed [MW:0]   pxy_reg;
    logic                 big_reg;
    logic [ITER_W-1:0]    k_reg;
    logic [7:0]           pix_reg;
    logic                 esc_reg;

    logic [PW-1:0]        px_next, py_next;
    logic signed [CW-1:0] cx_next, cy_next;
    logic signed [ZW-1:0] zx_next, zy_next;
    logic signed [ZW-1:0] zx_abs, zy_abs;
    logic [MW-1:0]        xm, ym;
    logic [2*MW-1:0]      prod_xx, prod_yy, prod_xy;
    logic [MW-1:0]        mag_xy;
    logic signed [MW:0]   pxy_next;
    logic                 big_next;
    logic [MW:0]          sq_sum;

    assign px_next = PW'(cfg.step_x) * PW'(col);
    assign py_next = PW'(cfg.step_y) * PW'(row);
    assign cx_next = CW'($signed(cfg.x_left)) + $signed({2'b00, px_reg});
    assign cy_next = CW'($signed(cfg.y_top)) - $signed({2'b00, py_reg});

    // z' = (zx^2 - zy^2 + cx, 2*zx*zy + cy) from the truncated products
    assign zx_next = ZW'($signed({1'b0, pxx_reg})) - ZW'($signed({1'b0, pyy_reg}))
                   + ZW'(cx_reg);
    assign zy_next = (ZW'(pxy_reg) <<< 1) + ZW'(cy_reg);

    // magnitudes only meaningful when |zx|, |zy| < 2; otherwise big_next wins
    assign zx_abs  = zx_reg[ZW-1] ? -zx_reg : zx_reg;
    assign zy_abs  = zy_reg[ZW-1] ? -zy_reg : zy_reg;
    assign xm      = zx_abs[MW-1:0];
    assign ym      = zy_abs[MW-1:0];
    assign prod_xx = xm * xm;
    assign prod_yy = ym * ym;
    assign prod_xy = xm * ym;
    assign mag_xy  = prod_xy[FRAC_BITS +: MW];
    assign pxy_next = (zx_reg[ZW-1] ^ zy_reg[ZW-1]) ? -$signed({1'b0, mag_xy})
                                                    : $signed({1'b0, mag_xy});
    assign big_next = (zx_reg >= TWO) || (zx_reg <= -TWO)
                   || (zy_reg >= TWO) || (zy_reg <= -TWO);

    // 4.0 is bit MW of the sum
    assign sq_sum = {1'b0, pxx_reg} + {1'b0, pyy_reg};

    assign status.esc    = big_reg || sq_sum[MW];
    assign status.at_max = (k_reg == cfg.max_iter);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.load_c)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            pxx_reg <= '0;
            pyy_reg <= '0;
            pxy_reg <= '0;
            big_reg <= 1'b0;
            k_reg   <= '0;
        end
        if (cmd.step)
        begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
            k_reg  <= k_reg + ITER_W'(1);
        end
        if (cmd.square)
        begin
            pxx_reg <= prod_xx[FRAC_BITS +: MW];
            pyy_reg <= prod_yy[FRAC_BITS +: MW];
            pxy_reg <= pxy_next;
            big_reg <= big_next;
        end
        if (cmd.load_out)
        begin
            pix_reg <= status.at_max ? 8'd0 : k_reg;
            esc_reg <= !status.at_max;
        end
    end

    assign pixel_value = pix_reg;
    assign escaped     = esc_reg;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time count for one pixel of the Mandelbrot set.
// ----------------------------------------------------------------------------
// Takes a pixel (row, col), forms c = (x_left + step_x*col, y_top - step_y*row)
// with FRAC_BITS fraction bits and iterates z = z*z + c from zero until
// |z|^2 >= 4 or max_iter steps have run. The result word carries the escape
// count (0 if the point never escaped before the limit) and an escaped flag.
// One pixel is in work at a time: the result word becomes valid in the same
// cycle as the block is ready to take the next pixel. The step/square loop
// sets how long a pixel takes: each step is a z update followed by a pass
// through the three multipliers. A finished result waits in an output
// register and the next pixel is accepted meanwhile; that pixel's loop holds
// at its end until the waiting word is taken. Registers must be written only
// while no pixel is in work; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
    import met_pkg::*;
#(
    parameter int FRAC_BITS   = 28,
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    pixel_in_if.sink               pix_in,
    pixel_out_if.source            pix_out
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    met_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    met_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dp (
        .clk         (clk),
        .cfg         (cfg),
        .row         (pix_in.row),
        .col         (pix_in.col),
        .cmd         (cmd),
        .status      (status),
        .pixel_value (pix_out.pixel_value),
        .escaped     (pix_out.escaped)
    );

endmodule

// ===== rtl/met_checker.sv =====
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks for the escape-time pixel block, bound to the top level.
// ----------------------------------------------------------------------------
module met_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_value,
    input logic       escaped
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // points that hit the limit report count 0
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !escaped |-> pixel_value == 8'd0)
        else $error("non-escaped point with nonzero count");

    // an escape needs at least one step
    a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && escaped |-> pixel_value != 8'd0)
        else $error("escaped point with zero count");

    // the block only goes busy by taking a word
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without an accepted word");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pix_in.valid),
    .in_ready    (pix_in.ready),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_value (pix_out.pixel_value),
    .escaped     (pix_out.escaped)
);
